[src/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/msst_pkg.sv]
package msst_pkg;

  localparam int unsigned LEAVES  = 1024;
  localparam int unsigned LEAF_W  = $clog2(LEAVES);
  localparam int unsigned NODES   = 2 * LEAVES;
  localparam int unsigned NODE_AW = $clog2(NODES);
  localparam int unsigned VAL_W   = 30;

  localparam logic [VAL_W-1:0] MODP = VAL_W'(1000000007);

  // request kinds
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // packed stream widths
  localparam int unsigned IN_BITS  = 1 + LEAF_W + VAL_W + LEAF_W + LEAF_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((VAL_W + 7) / 8) * 8;

  localparam int unsigned TYPE_LSB = 0;
  localparam int unsigned LEAF_LSB = 1;
  localparam int unsigned VAL_LSB  = LEAF_LSB + LEAF_W;
  localparam int unsigned LO_LSB   = VAL_LSB + VAL_W;
  localparam int unsigned HI_LSB   = LO_LSB + LEAF_W;

endpackage

[src/msst_modadd.sv]
// Modular adder: (a + b) mod MODP, valid when a + b < 2 * MODP.
module msst_modadd (
  input  logic [msst_pkg::VAL_W-1:0] op_a_i,
  input  logic [msst_pkg::VAL_W-1:0] op_b_i,
  output logic [msst_pkg::VAL_W-1:0] sum_o
);
  import msst_pkg::*;

  logic [VAL_W:0] raw;
  logic [VAL_W:0] red;

  assign raw = {1'b0, op_a_i} + {1'b0, op_b_i};
  assign red = raw - {1'b0, MODP};

  // one conditional subtract brings the sum back under the prime
  assign sum_o = (raw >= {1'b0, MODP}) ? red[VAL_W-1:0] : raw[VAL_W-1:0];

endmodule

[src/modular_sum_segment_tree_unit.sv]
// Channel  | Dir | Handshake                | Payload
// s_axis   | in  | s_axis_tvalid/tready     | req_type, leaf_index, add_value, range_lo, range_hi
// m_axis   | out | m_axis_tvalid/tready     | range_sum (queries only)
//
// Add: S_A_RD and S_A_LEAF update the leaf, then S_A_RL, S_A_RR and S_A_WR rebuild each
// parent up to the root. Query: S_Q_CHK per tree level, plus S_Q_ADDA and S_Q_ADDB for edge
// nodes. One single-port node RAM and one modular adder carry every step, so the RAM read
// latency plus the adder set the per-level cost. After reset the node RAM is swept to zero,
// one entry a cycle, with tready low. Input is taken only while the sequencer is idle; a
// finished query waits in the sequencer until the output register is free.
`include "assert_macros.svh"

module modular_sum_segment_tree_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [0] req_type, [10:1] leaf_index, [40:11] add_value, [50:41] range_lo,
  // [60:51] range_hi, [63:61] zero
  input  logic [msst_pkg::IN_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [29:0] range_sum, [31:30] zero
  output logic [msst_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import msst_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_RD   = 4'd2;
  localparam logic [3:0] S_A_LEAF = 4'd3;
  localparam logic [3:0] S_A_RL   = 4'd4;
  localparam logic [3:0] S_A_RR   = 4'd5;
  localparam logic [3:0] S_A_WR   = 4'd6;
  localparam logic [3:0] S_Q_CHK  = 4'd7;
  localparam logic [3:0] S_Q_ADDA = 4'd8;
  localparam logic [3:0] S_Q_ADDB = 4'd9;
  localparam logic [3:0] S_Q_OUT  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [NODE_AW-1:0] clr_q, clr_d;
  logic [NODE_AW-1:0] k_q, k_d;
  logic [NODE_AW-1:0] a_q, a_d;
  logic [NODE_AW-1:0] b_q, b_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [VAL_W-1:0]   tmp_q, tmp_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  logic [VAL_W-1:0]   out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [VAL_W-1:0]   mem [NODES];
  logic [VAL_W-1:0]   rdata_q;
  logic               rd_en, wr_en;
  logic [NODE_AW-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0]   wr_data;

  logic [VAL_W-1:0]   op_a, op_b, sum;
  logic [NODE_AW:0]   a_inc;
  logic [NODE_AW-1:0] b_dec;

  logic               in_type;
  logic [LEAF_W-1:0]  in_leaf, in_lo, in_hi;
  logic [VAL_W-1:0]   in_val;
  logic               in_fire, out_fire;

  assign in_type = s_axis_tdata_i[TYPE_LSB];
  assign in_leaf = s_axis_tdata_i[LEAF_LSB +: LEAF_W];
  assign in_val  = s_axis_tdata_i[VAL_LSB +: VAL_W];
  assign in_lo   = s_axis_tdata_i[LO_LSB +: LEAF_W];
  assign in_hi   = s_axis_tdata_i[HI_LSB +: LEAF_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_W - VAL_W){1'b0}}, out_q};

  assign a_inc = {1'b0, a_q} + 1'b1;
  assign b_dec = b_q - 1'b1;

  msst_modadd u_modadd (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .sum_o  (sum)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    a_d         = a_q;
    b_d         = b_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    acc_d       = acc_q;
    out_d       = out_q;
    out_valid_d = out_fire ? 1'b0 : out_valid_q;
    rd_en       = 1'b0;
    rd_addr     = k_q;
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = sum;
    op_a        = '0;
    op_b        = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == NODE_AW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          acc_d = '0;
          if (in_type == REQ_ADD) begin
            k_d     = NODE_AW'(in_leaf) + NODE_AW'(LEAVES);
            val_d   = in_val;
            state_d = S_A_RD;
          end else if (in_lo > in_hi) begin
            state_d = S_Q_OUT;
          end else begin
            a_d     = NODE_AW'(in_lo) + NODE_AW'(LEAVES);
            b_d     = NODE_AW'(in_hi) + NODE_AW'(LEAVES);
            state_d = S_Q_CHK;
          end
        end
      end
      S_A_RD: begin
        // fetch the leaf while reducing the add value
        rd_en   = 1'b1;
        rd_addr = k_q;
        op_a    = val_q;
        val_d   = sum;
        state_d = S_A_LEAF;
      end
      S_A_LEAF: begin
        op_a    = rdata_q;
        op_b    = val_q;
        wr_en   = 1'b1;
        wr_addr = k_q;
        k_d     = k_q >> 1;
        state_d = S_A_RL;
      end
      S_A_RL: begin
        rd_en   = 1'b1;
        rd_addr = {k_q[NODE_AW-2:0], 1'b0};
        state_d = S_A_RR;
      end
      S_A_RR: begin
        rd_en   = 1'b1;
        rd_addr = {k_q[NODE_AW-2:0], 1'b1};
        tmp_d   = rdata_q;
        state_d = S_A_WR;
      end
      S_A_WR: begin
        op_a    = tmp_q;
        op_b    = rdata_q;
        wr_en   = 1'b1;
        wr_addr = k_q;
        k_d     = k_q >> 1;
        state_d = (k_q == NODE_AW'(1)) ? S_IDLE : S_A_RL;
      end
      S_Q_CHK: begin
        priority if (a_q > b_q) begin
          state_d = S_Q_OUT;
        end else if (a_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = a_q;
          state_d = S_Q_ADDA;
        end else if (!b_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = b_q;
          state_d = S_Q_ADDB;
        end else begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
        end
      end
      S_Q_ADDA: begin
        op_a  = acc_q;
        op_b  = rdata_q;
        acc_d = sum;
        if (!b_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = b_q;
          a_d     = a_inc[NODE_AW-1:0];
          state_d = S_Q_ADDB;
        end else begin
          // step both bounds up one level
          a_d     = a_inc[NODE_AW:1];
          b_d     = b_q >> 1;
          state_d = S_Q_CHK;
        end
      end
      S_Q_ADDB: begin
        op_a    = acc_q;
        op_b    = rdata_q;
        acc_d   = sum;
        a_d     = a_q >> 1;
        b_d     = b_dec >> 1;
        state_d = S_Q_CHK;
      end
      S_Q_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_d       = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    a_q   <= a_d;
    b_q   <= b_d;
    val_q <= val_d;
    tmp_q <= tmp_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  `ASSERT_IMPL(a_result_reduced, clk_i, rst_ni, m_axis_tvalid_o, out_q < MODP)
  `ASSERT_IMPL(a_left_edge_odd, clk_i, rst_ni, state_q == S_Q_ADDA, a_q[0])
  `ASSERT_IMPL(a_right_edge_even, clk_i, rst_ni, state_q == S_Q_ADDB, !b_q[0])
  `ASSERT_IMPL(a_ascent_nonzero, clk_i, rst_ni, state_q == S_A_WR, k_q != '0)
  `ASSERT_NEXT(a_root_ends_add, clk_i, rst_ni,
               (state_q == S_A_WR) && (k_q == NODE_AW'(1)), state_q == S_IDLE)

endmodule
